[sv/kvt_pkg.sv]
// Shared types, field widths and request kind codes for the key/value table.
`timescale 1ns / 1ps

package kvt_pkg;

  localparam int KEY_WIDTH       = 32;
  localparam int VALUE_WIDTH     = 32;
  localparam int KIND_WIDTH      = 3;
  localparam int POS_WIDTH       = 8;
  localparam int COUNT_OUT_WIDTH = 9;
  localparam int CAPACITY        = 256;

  localparam logic [KIND_WIDTH-1:0] K_INSERT = 3'd0;
  localparam logic [KIND_WIDTH-1:0] K_UPDATE = 3'd1;
  localparam logic [KIND_WIDTH-1:0] K_UPSERT = 3'd2;
  localparam logic [KIND_WIDTH-1:0] K_ERASE  = 3'd3;
  localparam logic [KIND_WIDTH-1:0] K_LOOKUP = 3'd4;
  localparam logic [KIND_WIDTH-1:0] K_READ   = 3'd5;

  typedef struct packed {
    logic [KIND_WIDTH-1:0]  kind;
    logic [KEY_WIDTH-1:0]   key_in;
    logic [VALUE_WIDTH-1:0] value_in;
    logic [POS_WIDTH-1:0]   position;
  } request_t;

  typedef struct packed {
    logic                       success;
    logic [KEY_WIDTH-1:0]       key_out;
    logic [VALUE_WIDTH-1:0]     value_out;
    logic [COUNT_OUT_WIDTH-1:0] entry_count;
    logic                       is_empty;
  } result_t;

endpackage

[sv/kvt_store.sv]
// Entry storage: key and value memories with one write port and one registered read port.
`timescale 1ns / 1ps

module kvt_store #(
  parameter int DEPTH = kvt_pkg::CAPACITY,
  parameter int AW    = 8,
  parameter int KW    = kvt_pkg::KEY_WIDTH,
  parameter int VW    = kvt_pkg::VALUE_WIDTH
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [KW-1:0] wkey,
  input  logic [VW-1:0] wval,
  input  logic [AW-1:0] raddr,
  output logic [KW-1:0] rkey,
  output logic [VW-1:0] rval
);

  logic [KW-1:0] key_mem [DEPTH];
  logic [VW-1:0] val_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      val_mem[waddr] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    rkey <= key_mem[raddr];
    rval <= val_mem[raddr];
  end

endmodule

[sv/key_value_table_linear_search.sv]
// Key/value table top level: request sequencer, shared key comparator and result register.
// Requests are handled one at a time; the next request can already be accepted in the cycle in
// which done is high. A key search scans the held entries in order, a miss on insert or upsert
// appends at the end if there is room, and erase shifts every later entry down one place. Read
// by position reads one entry directly; unused kinds return a failed result and leave the table.
// Reset (rst, synchronous) empties the table; memory contents are not cleared.
`timescale 1ns / 1ps

module key_value_table_linear_search #(
  parameter int CAPACITY = kvt_pkg::CAPACITY
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  kvt_pkg::request_t request,
  output logic              busy,
  output logic              done,
  output kvt_pkg::result_t  result
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > kvt_pkg::POS_WIDTH) ? CW : kvt_pkg::POS_WIDTH;
  localparam int KW = kvt_pkg::KEY_WIDTH;
  localparam int VW = kvt_pkg::VALUE_WIDTH;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SEARCH    = 3'd1;
  localparam logic [2:0] S_SHIFT     = 3'd2;
  localparam logic [2:0] S_READ      = 3'd3;
  localparam logic [2:0] S_READ_WAIT = 3'd4;

  logic [2:0]        state, state_next;
  logic [CW-1:0]     idx, idx_next;
  logic              rd_valid, rd_valid_next;
  logic [CW-1:0]     rd_pos, rd_pos_next;
  logic [CW-1:0]     count, count_next;
  kvt_pkg::request_t req;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [KW-1:0] wkey, rkey;
  logic [VW-1:0] wval, rval;

  logic          match, scan_more, scan_end, has_room, pos_ok;
  logic [CW-1:0] rd_pos_m1;
  logic          fin, fin_ok;
  logic [KW-1:0] fin_key;
  logic [VW-1:0] fin_val;

  kvt_store #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .KW    (KW),
    .VW    (VW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wkey  (wkey),
    .wval  (wval),
    .raddr (raddr),
    .rkey  (rkey),
    .rval  (rval)
  );

  // The one key comparator, applied to the entry read in the previous cycle.
  assign match     = rd_valid && (rkey == req.key_in);
  assign scan_more = idx < count;
  // The scan is over once no read is in flight and every held entry was issued.
  assign scan_end  = !rd_valid && !scan_more;
  assign has_room  = count < CW'(CAPACITY);
  assign pos_ok    = PW'(req.position) < PW'(count);
  assign rd_pos_m1 = rd_pos - CW'(1);
  assign busy      = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    rd_valid_next = 1'b0;
    rd_pos_next   = rd_pos;
    count_next    = count;
    fin           = 1'b0;
    fin_ok        = 1'b0;
    fin_key       = '0;
    fin_val       = '0;
    we            = 1'b0;
    waddr         = rd_pos[AW-1:0];
    wkey          = req.key_in;
    wval          = req.value_in;
    raddr         = idx[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (start) begin
          idx_next = '0;
          if (request.kind == kvt_pkg::K_READ) begin
            state_next = S_READ;
          end else if (request.kind <= kvt_pkg::K_LOOKUP) begin
            state_next = S_SEARCH;
          end else begin
            fin = 1'b1;
          end
        end
      end
      S_SEARCH: begin
        rd_valid_next = scan_more;
        rd_pos_next   = idx;
        if (scan_more) begin
          idx_next = idx + CW'(1);
        end
        if (match) begin
          unique case (req.kind)
            kvt_pkg::K_UPDATE, kvt_pkg::K_UPSERT: begin
              we     = 1'b1;
              fin    = 1'b1;
              fin_ok = 1'b1;
            end
            kvt_pkg::K_ERASE: begin
              state_next    = S_SHIFT;
              idx_next      = rd_pos + CW'(1);
              rd_valid_next = 1'b0;
            end
            kvt_pkg::K_LOOKUP: begin
              fin     = 1'b1;
              fin_ok  = 1'b1;
              fin_val = rval;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end else if (scan_end) begin
          fin = 1'b1;
          if ((req.kind == kvt_pkg::K_INSERT || req.kind == kvt_pkg::K_UPSERT) && has_room) begin
            we         = 1'b1;
            waddr      = count[AW-1:0];
            count_next = count + CW'(1);
            fin_ok     = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        // Read entry idx, and in the following cycle write it back one place lower.
        rd_valid_next = scan_more;
        rd_pos_next   = idx;
        if (scan_more) begin
          idx_next = idx + CW'(1);
        end
        if (rd_valid) begin
          we    = 1'b1;
          waddr = rd_pos_m1[AW-1:0];
          wkey  = rkey;
          wval  = rval;
        end
        if (scan_end) begin
          fin        = 1'b1;
          fin_ok     = 1'b1;
          count_next = count - CW'(1);
        end
      end
      S_READ: begin
        raddr      = AW'(req.position);
        state_next = S_READ_WAIT;
      end
      S_READ_WAIT: begin
        fin = 1'b1;
        if (pos_ok) begin
          fin_ok  = 1'b1;
          fin_key = rkey;
          fin_val = rval;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
      idx      <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      rd_valid <= rd_valid_next;
      done     <= fin;
      idx      <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_pos <= rd_pos_next;
    if (state == S_IDLE && start) begin
      req <= request;
    end
    if (fin) begin
      result.success     <= fin_ok;
      result.key_out     <= fin_key;
      result.value_out   <= fin_val;
      result.entry_count <= kvt_pkg::COUNT_OUT_WIDTH'(count_next);
      result.is_empty    <= (count_next == '0);
    end
  end

endmodule

[bench/key_value_table_linear_search_tb.sv]
// Self-checking bench for the key/value table: a directed request table, then random phases.
`timescale 1ns / 1ps

module key_value_table_linear_search_tb;

  // The two kind codes that the block leaves unused.
  localparam logic [kvt_pkg::KIND_WIDTH-1:0] K_SPARE6 = 3'd6;
  localparam logic [kvt_pkg::KIND_WIDTH-1:0] K_SPARE7 = 3'd7;

  localparam int     RANDOM_ITEMS  = 1826;
  localparam int     POOL_SIZE     = 384;
  localparam int     MIX_KEYS      = 32;
  localparam int     SETTLE_CYCLES = 2 * kvt_pkg::CAPACITY + 64;
  localparam longint CYCLE_LIMIT   = 8000000;

  typedef struct {
    kvt_pkg::request_t req;
    bit                fixed;
    kvt_pkg::result_t  res;
  } stim_row_t;

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              start   = 1'b0;
  kvt_pkg::request_t request = '0;
  logic              busy;
  logic              done;
  kvt_pkg::result_t  result;

  key_value_table_linear_search DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  // Shadow copy of the table contents.
  logic [kvt_pkg::KEY_WIDTH-1:0]   tbl_keys [kvt_pkg::CAPACITY];
  logic [kvt_pkg::VALUE_WIDTH-1:0] tbl_vals [kvt_pkg::CAPACITY];
  int held         = 0;
  int peak_held    = 0;
  int full_rejects = 0;

  kvt_pkg::result_t              replies_due [$];
  stim_row_t                     directed_rows [$];
  logic [kvt_pkg::KEY_WIDTH-1:0] key_pool [POOL_SIZE];
  int                            kind_seen [8];
  int                            burst_left = 0;
  int                            sent       = 0;
  int                            checked    = 0;
  int                            errors     = 0;
  longint                        cycles     = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Applies one request to the shadow table and returns the reply it should produce.
  function automatic kvt_pkg::result_t compute_reply(kvt_pkg::request_t r);
    kvt_pkg::result_t res;
    int hit;
    res = '0;
    hit = held;
    for (int i = 0; i < held; i++)
      if (hit == held && tbl_keys[i] == r.key_in) hit = i;
    case (r.kind)
      kvt_pkg::K_INSERT, kvt_pkg::K_UPSERT: begin
        if (hit < held && r.kind == kvt_pkg::K_UPSERT) begin
          tbl_vals[hit] = r.value_in;
          res.success = 1'b1;
        end else if (hit == held && held < kvt_pkg::CAPACITY) begin
          tbl_keys[held] = r.key_in;
          tbl_vals[held] = r.value_in;
          held++;
          res.success = 1'b1;
        end else if (hit == held) begin
          full_rejects++;
        end
      end
      kvt_pkg::K_UPDATE: if (hit < held) begin
        tbl_vals[hit] = r.value_in;
        res.success = 1'b1;
      end
      kvt_pkg::K_ERASE: if (hit < held) begin
        for (int j = hit; j + 1 < held; j++) begin
          tbl_keys[j] = tbl_keys[j + 1];
          tbl_vals[j] = tbl_vals[j + 1];
        end
        held--;
        res.success = 1'b1;
      end
      kvt_pkg::K_LOOKUP: if (hit < held) begin
        res.value_out = tbl_vals[hit];
        res.success = 1'b1;
      end
      kvt_pkg::K_READ: if (int'(r.position) < held) begin
        res.key_out = tbl_keys[r.position];
        res.value_out = tbl_vals[r.position];
        res.success = 1'b1;
      end
      default: ;
    endcase
    if (held > peak_held) peak_held = held;
    res.entry_count = kvt_pkg::COUNT_OUT_WIDTH'(held);
    res.is_empty = (held == 0);
    return res;
  endfunction

  task automatic add_row(logic [kvt_pkg::KIND_WIDTH-1:0] kind,
                         logic [kvt_pkg::KEY_WIDTH-1:0] key,
                         logic [kvt_pkg::VALUE_WIDTH-1:0] value,
                         logic [kvt_pkg::POS_WIDTH-1:0] pos,
                         bit fixed = 1'b0, bit ok = 1'b0,
                         logic [kvt_pkg::KEY_WIDTH-1:0] kout = '0,
                         logic [kvt_pkg::VALUE_WIDTH-1:0] vout = '0, int count = 0);
    stim_row_t row;
    row.req = '{kind: kind, key_in: key, value_in: value, position: pos};
    row.fixed = fixed;
    row.res = '{success: ok, key_out: kout, value_out: vout,
                entry_count: kvt_pkg::COUNT_OUT_WIDTH'(count), is_empty: (count == 0)};
    directed_rows.push_back(row);
  endtask

  // Holds the request on the port until accepted, with random gaps between bursts.
  task automatic issue_request(kvt_pkg::request_t r, bit fixed, kvt_pkg::result_t fixed_res);
    kvt_pkg::result_t predicted;
    int gap_max;
    if (burst_left == 0) begin
      gap_max = ($urandom_range(0, 1) == 1) ? 6 : 2 * held + 8;
      start <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy !== 1'b0);
    burst_left--;
    predicted = compute_reply(r);
    replies_due.push_back(fixed ? fixed_res : predicted);
    kind_seen[r.kind]++;
    sent++;
  endtask

  task automatic wait_for_replies();
    start <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  // Picks a held key with a chance of held_pct percent, otherwise one from the first pool_span entries of the pool.
  function automatic logic [kvt_pkg::KEY_WIDTH-1:0] pick_key(int held_pct, int pool_span);
    if (held > 0 && $urandom_range(0, 99) < held_pct)
      return tbl_keys[$urandom_range(0, held - 1)];
    return key_pool[$urandom_range(0, pool_span - 1)];
  endfunction

  function automatic kvt_pkg::request_t random_request(int held_pct, int pool_span);
    kvt_pkg::request_t r;
    int roll;
    r.key_in = pick_key(held_pct, pool_span);
    r.value_in = $urandom;
    if (held > 0 && $urandom_range(0, 9) < 7)
      r.position = kvt_pkg::POS_WIDTH'($urandom_range(0,
                   (held < kvt_pkg::CAPACITY) ? held : kvt_pkg::CAPACITY - 1));
    else
      r.position = kvt_pkg::POS_WIDTH'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 20) r.kind = kvt_pkg::K_INSERT;
    else if (roll < 30) r.kind = kvt_pkg::K_UPDATE;
    else if (roll < 45) r.kind = kvt_pkg::K_UPSERT;
    else if (roll < 65) r.kind = kvt_pkg::K_ERASE;
    else if (roll < 80) r.kind = kvt_pkg::K_LOOKUP;
    else if (roll < 95) r.kind = kvt_pkg::K_READ;
    else if (roll < 97) r.kind = K_SPARE6;
    else r.kind = K_SPARE7;
    return r;
  endfunction

  initial begin
    kvt_pkg::request_t r;
    int n;
    int fill_next;
    int full_ops;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // Empty table first, then extreme keys and values, duplicates and out-of-range reads.
    add_row(kvt_pkg::K_LOOKUP, 32'h0, 32'h0, 8'h00, 1'b1, 1'b0, 0, 0, 0);
    add_row(kvt_pkg::K_READ, 32'h0, 32'h0, 8'h00, 1'b1, 1'b0, 0, 0, 0);
    add_row(kvt_pkg::K_ERASE, 32'hFFFF_FFFF, 32'h0, 8'h00, 1'b1, 1'b0, 0, 0, 0);
    add_row(kvt_pkg::K_UPDATE, 32'h0, 32'h0000_1234, 8'h00, 1'b1, 1'b0, 0, 0, 0);
    add_row(K_SPARE6, 32'h0, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b0, 0, 0, 0);
    add_row(kvt_pkg::K_INSERT, 32'h0, 32'hFFFF_FFFF, 8'h00, 1'b1, 1'b1, 0, 0, 1);
    add_row(kvt_pkg::K_INSERT, 32'hFFFF_FFFF, 32'h0, 8'hFF, 1'b1, 1'b1, 0, 0, 2);
    add_row(kvt_pkg::K_INSERT, 32'h0, 32'h5, 8'h00, 1'b1, 1'b0, 0, 0, 2);
    add_row(kvt_pkg::K_LOOKUP, 32'h0, 32'h0, 8'h00, 1'b1, 1'b1, 0, 32'hFFFF_FFFF, 2);
    add_row(kvt_pkg::K_READ, 32'h0, 32'h0, 8'h01, 1'b1, 1'b1, 32'hFFFF_FFFF, 0, 2);
    add_row(kvt_pkg::K_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b0, 0, 0, 2);
    add_row(kvt_pkg::K_READ, 32'h0, 32'h0, 8'h02, 1'b1, 1'b0, 0, 0, 2);
    add_row(kvt_pkg::K_UPDATE, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 8'h00);
    add_row(kvt_pkg::K_UPSERT, 32'h1234_5678, 32'h5A5A_5A5A, 8'h00);
    add_row(kvt_pkg::K_UPSERT, 32'h0, 32'h1, 8'h00);
    add_row(K_SPARE7, 32'h0, 32'hFFFF_FFFF, 8'h00, 1'b1, 1'b0, 0, 0, 3);
    add_row(kvt_pkg::K_ERASE, 32'h0, 32'h0, 8'h00);
    add_row(kvt_pkg::K_READ, 32'h0, 32'h0, 8'h00);
    add_row(kvt_pkg::K_READ, 32'h0, 32'h0, 8'h01);
    add_row(kvt_pkg::K_LOOKUP, 32'h0, 32'h0, 8'h00, 1'b1, 1'b0, 0, 0, 2);
    add_row(kvt_pkg::K_UPDATE, 32'h1234_5678, 32'hFFFF_FFFF, 8'h00);
    add_row(kvt_pkg::K_ERASE, 32'h1234_5678, 32'h0, 8'h00);
    add_row(kvt_pkg::K_ERASE, 32'hFFFF_FFFF, 32'h0, 8'h00);
    add_row(kvt_pkg::K_UPSERT, 32'h8000_0000, 32'h8000_0000, 8'h80, 1'b1, 1'b1, 0, 0, 1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].res);
    wait_for_replies();

    // Fill to capacity, then keep the table full for a while so the rejections get exercised.
    n = 0;
    fill_next = 0;
    full_ops = 0;
    while (n < RANDOM_ITEMS && full_ops < 40) begin
      if (held == kvt_pkg::CAPACITY) begin
        full_ops++;
        r = random_request(50, POOL_SIZE);
      end else if ($urandom_range(0, 99) < 85) begin
        r = random_request(0, POOL_SIZE);
        r.kind = ($urandom_range(0, 3) == 0) ? kvt_pkg::K_UPSERT : kvt_pkg::K_INSERT;
        r.key_in = key_pool[fill_next % POOL_SIZE];
        fill_next++;
      end else begin
        r = random_request(50, POOL_SIZE);
      end
      issue_request(r, 1'b0, '0);
      n++;
    end
    wait_for_replies();

    // Erasing held keys at random positions drains the table through long shifts.
    while (n < RANDOM_ITEMS && held > 12) begin
      r = random_request(100, POOL_SIZE);
      if ($urandom_range(0, 99) < 80) r.kind = kvt_pkg::K_ERASE;
      issue_request(r, 1'b0, '0);
      n++;
    end
    wait_for_replies();

    // The rest stays small: a narrow key pool keeps hits frequent and searches short.
    while (n < RANDOM_ITEMS) begin
      issue_request(random_request(40, MIX_KEYS), 1'b0, '0);
      n++;
    end
    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d insert, %0d update, %0d upsert, %0d erase, %0d lookup,",
             sent, kind_seen[kvt_pkg::K_INSERT], kind_seen[kvt_pkg::K_UPDATE],
             kind_seen[kvt_pkg::K_UPSERT], kind_seen[kvt_pkg::K_ERASE],
             kind_seen[kvt_pkg::K_LOOKUP]);
    $display("%0d read, %0d unused kind; peak fill %0d of %0d, %0d rejected for room, %0d checked.",
             kind_seen[kvt_pkg::K_READ], kind_seen[K_SPARE6] + kind_seen[K_SPARE7], peak_held,
             kvt_pkg::CAPACITY, full_rejects, checked);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Results are sampled mid-cycle, away from the edge where requests are pushed.
  always @(negedge clk) begin
    kvt_pkg::result_t want;
    if (!rst && done === 1'b1) begin
      if (replies_due.size() == 0) begin
        $display("%0t: result with no request outstanding: expected none, actual %p",
                 $time, result);
        errors++;
      end else begin
        want = replies_due.pop_front();
        check_field("success", 32'(want.success), 32'(result.success));
        check_field("key_out", want.key_out, result.key_out);
        check_field("value_out", want.value_out, result.value_out);
        check_field("entry_count", 32'(want.entry_count), 32'(result.entry_count));
        check_field("is_empty", 32'(want.is_empty), 32'(result.is_empty));
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, replies_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

[filelist.f]
sv/kvt_pkg.sv
sv/kvt_store.sv
sv/key_value_table_linear_search.sv
bench/key_value_table_linear_search_tb.sv
